// File: sv/nmf_pkg.sv
// ----------------------------------------------------------------------------
// nmf_pkg
// Shared types and constants for the 3x3 neighbour median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package nmf_pkg;

   localparam int CH_W     = 8;
   localparam int NB_COUNT = 8;
   localparam int REG_W    = 12;

   localparam logic [REG_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [REG_W-1:0] HEIGHT_RESET = 12'd480;
   localparam logic [REG_W-1:0] MIN_DIM      = 12'd3;

   // register indexes
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // item kinds
   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   // packed as in the line stores: blue in the low byte, red on top
   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_type;

   typedef logic [NB_COUNT-1:0][CH_W-1:0] nbr_set_type;

   typedef struct packed {
      logic filter;
      logic row_end;
      logic frame_end;
   } emit_ctl_type;

endpackage

`default_nettype wire

// File: sv/nmf_line_buf.sv
// ----------------------------------------------------------------------------
// nmf_line_buf
// One row store: single write port, one registered read port, write-first.
// ----------------------------------------------------------------------------
`default_nettype none

module nmf_line_buf #(
   parameter int DEPTH = 2048
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire  nmf_pkg::pixel_type     wr_data,
   input  wire                          rd_en,
   input  wire  [$clog2(DEPTH)-1:0]     rd_addr,
   output nmf_pkg::pixel_type           rd_data
);
   import nmf_pkg::*;

   pixel_type mem [DEPTH];
   pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // a read at the address written in the same cycle sees the new data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/nmf_median_lane.sv
// ----------------------------------------------------------------------------
// nmf_median_lane
// Median of eight 8-bit values: floor of mean of 4th and 5th smallest.
// ----------------------------------------------------------------------------
`default_nettype none

module nmf_median_lane (
   input  wire                          clock,
   input  wire                          enable,
   input  wire  nmf_pkg::nbr_set_type   nbrs,
   output logic [nmf_pkg::CH_W-1:0]     median
);
   import nmf_pkg::*;

   logic [2:0]      rank [NB_COUNT];
   logic [CH_W-1:0] low_val;
   logic [CH_W-1:0] high_val;
   logic [CH_W:0]   pair_sum;
   logic [CH_W-1:0] median_ff;
   logic [CH_W-1:0] median_in;

   // rank by count of smaller values; ties broken by position so ranks are unique
   always_comb begin
      for (int i = 0; i < NB_COUNT; i++) begin
         rank[i] = 3'd0;
         for (int j = 0; j < NB_COUNT; j++) begin
            if (j != i) begin
               if ((nbrs[j] < nbrs[i]) || ((nbrs[j] == nbrs[i]) && (j < i))) begin
                  rank[i] = rank[i] + 3'd1;
               end
            end
         end
      end
   end

   always_comb begin
      low_val  = '0;
      high_val = '0;
      for (int i = 0; i < NB_COUNT; i++) begin
         if (rank[i] == 3'd3) begin
            low_val = low_val | nbrs[i];
         end
         if (rank[i] == 3'd4) begin
            high_val = high_val | nbrs[i];
         end
      end
      pair_sum  = {1'b0, low_val} + {1'b0, high_val};
      median_in = pair_sum[CH_W:1];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         median_ff <= median_in;
      end
   end

   assign median = median_ff;

endmodule

`default_nettype wire

// File: sv/neighbour_median_filter_rgb_core.sv
// Pipeline: 3 register stages, stage 1, stage 2 and the result register.
// Throughput: one item per cycle; the pipeline advances whenever the result
// register is empty or being taken, so at most one line-store read and one write per cycle.
// Results lag pixels by w_eff+1 pixels (frame_width clamped to 3..MAX_WIDTH); flush items drain the held tail.
// Reset (synchronous): counters cleared, window zeroed, registers to 640 x 480.
// Line stores are not cleared; their unwritten entries never reach a result.
// ----------------------------------------------------------------------------
// neighbour_median_filter_rgb_core
// 3x3 neighbour median filter over an RGB raster stream, one lane per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbour_median_filter_rgb_core #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire                          req_action,
   input  wire  [nmf_pkg::CH_W-1:0]     req_in_blue,
   input  wire  [nmf_pkg::CH_W-1:0]     req_in_green,
   input  wire  [nmf_pkg::CH_W-1:0]     req_in_red,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [nmf_pkg::CH_W-1:0]     rsp_out_blue,
   output logic [nmf_pkg::CH_W-1:0]     rsp_out_green,
   output logic [nmf_pkg::CH_W-1:0]     rsp_out_red,
   output logic                         rsp_out_row_end,
   output logic                         rsp_out_frame_end,
   input  wire                          csr_we,
   input  wire                          csr_index,
   input  wire  [nmf_pkg::REG_W-1:0]    csr_wdata
);
   import nmf_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_WIDTH + 2);

   logic [REG_W-1:0] frame_width_ff, frame_width_in;
   logic [REG_W-1:0] frame_height_ff, frame_height_in;
   logic [CW-1:0]    w_eff;
   logic [REG_W-1:0] h_eff;

   logic [AW-1:0]    col_ff, col_in;
   logic [HW-1:0]    held_ff, held_in;
   logic [AW-1:0]    ocol_ff, ocol_in;
   logic [REG_W-1:0] orow_ff, orow_in;

   logic             adv, acc, is_pix, produce;
   logic [AW-1:0]    last_col;
   logic [HW-1:0]    depth_d;
   logic             d_in_mid;
   logic [CW:0]      mod_sum;
   logic [AW-1:0]    mid_rd_addr, up_rd_addr;
   emit_ctl_type     ctl_now;
   pixel_type        req_pixel;

   // stage 1
   logic             s1_valid_ff, s1_pix_ff, s1_produce_ff, s1_use_up_ff;
   logic [AW-1:0]    s1_col_ff;
   pixel_type        s1_data_ff;
   emit_ctl_type     s1_ctl_ff;
   pixel_type        up_rd, mid_rd;
   logic             s1_write;

   pixel_type        window_ff [9];
   pixel_type        window_in [9];

   // stage 2
   logic             s2_valid_ff;
   emit_ctl_type     s2_ctl_ff;
   pixel_type        s2_centre_ff, s2_centre_in;
   pixel_type        s2_nb_ff [NB_COUNT];
   nbr_set_type      nb_blue, nb_green, nb_red;

   // result register
   logic             rsp_valid_ff;
   emit_ctl_type     rsp_ctl_ff;
   pixel_type        rsp_centre_ff;
   logic [CH_W-1:0]  med_blue, med_green, med_red;

   // ---------------- registers and effective sizes ----------------
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            REG_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default:          frame_width_in  = frame_width_ff;
         endcase
      end
   end

   always_comb begin
      priority if (frame_width_ff < MIN_DIM) begin
         w_eff = CW'(3);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(frame_width_ff);
      end
      h_eff = (frame_height_ff < MIN_DIM) ? MIN_DIM : frame_height_ff;
   end

   // ---------------- accept stage: counters and read addresses ----------------
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign acc       = req_valid && adv;
   assign is_pix    = (req_action == ACT_PIXEL);
   assign req_pixel = '{red: req_in_red, green: req_in_green, blue: req_in_blue};

   always_comb begin
      last_col    = (col_ff == '0) ? AW'(w_eff - CW'(1)) : col_ff - AW'(1);
      depth_d     = held_ff - HW'(1);
      d_in_mid    = (32'(depth_d) < 32'(w_eff));
      mod_sum     = (CW+1)'(last_col) + (CW+1)'(w_eff) - (CW+1)'(depth_d);
      if (mod_sum >= (CW+1)'(w_eff)) begin
         mod_sum = mod_sum - (CW+1)'(w_eff);
      end
      mid_rd_addr = is_pix ? col_ff : AW'(mod_sum);
      up_rd_addr  = is_pix ? col_ff : last_col;
   end

   always_comb begin
      col_in  = col_ff;
      held_in = held_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      produce = 1'b0;
      if (is_pix) begin
         col_in = (32'(col_ff) + 1 >= 32'(w_eff)) ? '0 : col_ff + AW'(1);
         if (32'(held_ff) >= 32'(w_eff) + 1) begin
            held_in = HW'(w_eff) + HW'(1);
            produce = 1'b1;
         end else begin
            held_in = held_ff + HW'(1);
         end
      end else if (held_ff != '0) begin
         held_in = held_ff - HW'(1);
         produce = 1'b1;
      end
      ctl_now.row_end   = (32'(ocol_ff) + 1 >= 32'(w_eff));
      ctl_now.frame_end = ctl_now.row_end && (orow_ff >= h_eff - REG_W'(1));
      ctl_now.filter    = is_pix && !(ocol_ff == '0 || ctl_now.row_end ||
                                      orow_ff == '0 || orow_ff >= h_eff - REG_W'(1));
      if (produce) begin
         if (ctl_now.row_end) begin
            ocol_in = '0;
            orow_in = (orow_ff + REG_W'(1) >= h_eff) ? '0 : orow_ff + REG_W'(1);
         end else begin
            ocol_in = ocol_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
         col_ff          <= '0;
         held_ff         <= '0;
         ocol_ff         <= '0;
         orow_ff         <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         if (csr_we) begin
            col_ff  <= '0;
            held_ff <= '0;
            ocol_ff <= '0;
            orow_ff <= '0;
         end else if (acc) begin
            col_ff  <= col_in;
            held_ff <= held_in;
            ocol_ff <= ocol_in;
            orow_ff <= orow_in;
         end
      end
   end

   // ---------------- line stores ----------------
   assign s1_write = adv && s1_valid_ff && s1_pix_ff;

   nmf_line_buf #(.DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (acc),
      .rd_addr (up_rd_addr),
      .rd_data (up_rd)
   );

   nmf_line_buf #(.DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_col_ff),
      .wr_data (s1_data_ff),
      .rd_en   (acc),
      .rd_addr (mid_rd_addr),
      .rd_data (mid_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= acc && (is_pix || produce);
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pix_ff     <= is_pix;
         s1_produce_ff <= produce;
         s1_use_up_ff  <= !d_in_mid;
         s1_col_ff     <= col_ff;
         s1_data_ff    <= req_pixel;
         s1_ctl_ff     <= ctl_now;
      end
   end

   // ---------------- window shift ----------------
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         window_in[r*3]     = window_ff[r*3+1];
         window_in[r*3 + 1] = window_ff[r*3+2];
      end
      window_in[2] = up_rd;
      window_in[5] = mid_rd;
      window_in[8] = s1_data_ff;
      if (s1_pix_ff) begin
         s2_centre_in = window_in[4];
      end else begin
         s2_centre_in = s1_use_up_ff ? up_rd : mid_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            window_ff[k] <= '0;
         end
      end else if (s1_write) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_produce_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ctl_ff    <= s1_ctl_ff;
         s2_centre_ff <= s2_centre_in;
         for (int k = 0; k < NB_COUNT; k++) begin
            s2_nb_ff[k] <= window_in[(k < 4) ? k : k + 1];
         end
      end
   end

   // ---------------- channel lanes ----------------
   always_comb begin
      for (int k = 0; k < NB_COUNT; k++) begin
         nb_blue[k]  = s2_nb_ff[k].blue;
         nb_green[k] = s2_nb_ff[k].green;
         nb_red[k]   = s2_nb_ff[k].red;
      end
   end

   nmf_median_lane u_lane_blue (
      .clock (clock), .enable (adv), .nbrs (nb_blue), .median (med_blue)
   );

   nmf_median_lane u_lane_green (
      .clock (clock), .enable (adv), .nbrs (nb_green), .median (med_green)
   );

   nmf_median_lane u_lane_red (
      .clock (clock), .enable (adv), .nbrs (nb_red), .median (med_red)
   );

   // ---------------- merge / result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ctl_ff    <= s2_ctl_ff;
         rsp_centre_ff <= s2_centre_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_blue      = rsp_ctl_ff.filter ? med_blue  : rsp_centre_ff.blue;
   assign rsp_out_green     = rsp_ctl_ff.filter ? med_green : rsp_centre_ff.green;
   assign rsp_out_red       = rsp_ctl_ff.filter ? med_red   : rsp_centre_ff.red;
   assign rsp_out_row_end   = rsp_ctl_ff.row_end;
   assign rsp_out_frame_end = rsp_ctl_ff.frame_end;

endmodule

`default_nettype wire
